FILE: src/line_token_highlighter_core_defines.svh
// Assertion macros shared by the line token highlighter RTL.
`ifndef LINE_TOKEN_HIGHLIGHTER_CORE_DEFINES_SVH
`define LINE_TOKEN_HIGHLIGHTER_CORE_DEFINES_SVH

// Plain invariant, checked at every clock edge outside reset.
`define LTH_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Same-cycle implication, checked at every clock edge outside reset.
`define LTH_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);

`endif

FILE: src/lth_pkg.sv
// Types, constants and helper functions of the line token highlighter.
package lth_pkg;

  localparam int unsigned LINE_LEN   = 96;
  localparam int unsigned MAX_TOKENS = 4;
  localparam int unsigned WORD_CAP   = 23;
  localparam int unsigned LINE_COUNT = 128;

  // Longest keyword; only this many leading identifier characters are kept.
  localparam int unsigned HEAD_CHARS = 6;
  localparam int unsigned HEAD_W     = 8 * HEAD_CHARS;

  localparam int unsigned COL_W  = 7;
  localparam int unsigned CNT_W  = 3;
  localparam int unsigned LEN_W  = 5;
  localparam int unsigned TYPE_W = 4;
  localparam int unsigned MODE_W = 3;
  localparam int unsigned LINE_W = 7;

  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = 2;
  localparam int unsigned QCNT_W = 3;

  // Scanner modes.
  localparam logic [MODE_W-1:0] MODE_IDLE    = 3'd0;
  localparam logic [MODE_W-1:0] MODE_STR     = 3'd1;
  localparam logic [MODE_W-1:0] MODE_STR_ESC = 3'd2;
  localparam logic [MODE_W-1:0] MODE_NUM     = 3'd3;
  localparam logic [MODE_W-1:0] MODE_WORD    = 3'd4;
  localparam logic [MODE_W-1:0] MODE_CMT     = 3'd5;
  localparam logic [MODE_W-1:0] MODE_PP      = 3'd6;

  // Result record types.
  localparam logic [TYPE_W-1:0] TOK_ABSENT  = 4'd0;
  localparam logic [TYPE_W-1:0] TOK_SUMMARY = 4'd0;
  localparam logic [TYPE_W-1:0] TOK_KW      = 4'd1;
  localparam logic [TYPE_W-1:0] TOK_STR     = 4'd2;
  localparam logic [TYPE_W-1:0] TOK_CMT     = 4'd3;
  localparam logic [TYPE_W-1:0] TOK_NUM     = 4'd4;
  localparam logic [TYPE_W-1:0] TOK_TYP     = 4'd5;
  localparam logic [TYPE_W-1:0] TOK_FN      = 4'd6;
  localparam logic [TYPE_W-1:0] TOK_OP      = 4'd7;
  localparam logic [TYPE_W-1:0] TOK_PP      = 4'd8;

  // Input item request kinds.
  localparam logic REQ_CHAR = 1'b0;
  localparam logic REQ_EOL  = 1'b1;

  typedef struct packed {
    logic       req_type;
    logic [7:0] ch;
  } lth_in_t;

  typedef struct packed {
    logic [TYPE_W-1:0] tok_type;
    logic [COL_W-1:0]  tok_start;
    logic [COL_W-1:0]  tok_end;
    logic [LINE_W-1:0] line_index;
    logic [CNT_W-1:0]  token_count;
    logic              line_done;
  } lth_out_t;

  // Records produced by one accepted transaction, rec0 first.
  typedef struct packed {
    logic [1:0] n;
    lth_out_t   rec0;
    lth_out_t   rec1;
  } lth_push_t;

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  // The head holds the identifier with its last character in the low byte,
  // so a word of n characters sits in the low 8*n bits.
  function automatic logic [TYPE_W-1:0] word_kind(input logic [HEAD_W-1:0] h,
                                                  input logic [LEN_W-1:0] n);
    logic [TYPE_W-1:0] k;
    k = TOK_ABSENT;
    unique case (n)
      5'd2: begin
        if (h[15:0] == "if") k = TOK_KW;
      end
      5'd3: begin
        if (h[23:0] == "int") k = TOK_TYP;
        else if (h[23:0] == "for") k = TOK_KW;
      end
      5'd4: begin
        if (h[31:0] == "void" || h[31:0] == "char") k = TOK_TYP;
        else if (h[31:0] == "else" || h[31:0] == "case") k = TOK_KW;
      end
      5'd5: begin
        if (h[39:0] == "while" || h[39:0] == "const" || h[39:0] == "break") k = TOK_KW;
      end
      5'd6: begin
        if (h[47:0] == "return" || h[47:0] == "static" || h[47:0] == "struct" ||
            h[47:0] == "switch") k = TOK_KW;
      end
      default: k = TOK_ABSENT;
    endcase
    return k;
  endfunction

endpackage

FILE: src/lth_scan.sv
// Line scanner: holds the per-line state and turns each transaction into records.
`include "line_token_highlighter_core_defines.svh"

module lth_scan (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               accept_i,
  input  lth_pkg::lth_in_t   in_data_i,
  output lth_pkg::lth_push_t push_o
);

  logic [lth_pkg::MODE_W-1:0] mode_q, mode_d;
  logic                       slash_q, slash_d;
  logic [lth_pkg::HEAD_W-1:0] head_q, head_d;
  logic [lth_pkg::LEN_W-1:0]  len_q, len_d;
  logic [lth_pkg::COL_W-1:0]  tb_q, tb_d;
  logic [lth_pkg::COL_W-1:0]  col_q, col_d;
  logic [lth_pkg::CNT_W-1:0]  emit_q, emit_d;
  logic [lth_pkg::LINE_W-1:0] line_q, line_d;

  logic [7:0]                 c;
  logic                       a_vld, s_vld, start_en;
  logic [lth_pkg::TYPE_W-1:0] kind;
  lth_pkg::lth_out_t          a_rec, s_rec;

  assign c = in_data_i.ch;

  function automatic lth_pkg::lth_out_t tok_rec(input logic [lth_pkg::TYPE_W-1:0] t,
                                                input logic [lth_pkg::COL_W-1:0] s,
                                                input logic [lth_pkg::COL_W-1:0] e,
                                                input logic [lth_pkg::LINE_W-1:0] l);
    lth_pkg::lth_out_t r;
    r.tok_type    = t;
    r.tok_start   = s;
    r.tok_end     = e;
    r.line_index  = l;
    r.token_count = '0;
    r.line_done   = 1'b0;
    return r;
  endfunction

  always_comb begin
    mode_d   = mode_q;
    slash_d  = slash_q;
    head_d   = head_q;
    len_d    = len_q;
    tb_d     = tb_q;
    col_d    = col_q;
    line_d   = line_q;
    a_vld    = 1'b0;
    s_vld    = 1'b0;
    start_en = 1'b0;
    kind     = lth_pkg::TOK_ABSENT;
    a_rec    = tok_rec(lth_pkg::TOK_ABSENT, tb_q, tb_q, line_q);
    s_rec    = tok_rec(lth_pkg::TOK_ABSENT, col_q, col_q, line_q);

    if (in_data_i.req_type == lth_pkg::REQ_CHAR) begin
      if (col_q < lth_pkg::COL_W'(lth_pkg::LINE_LEN)) begin
        if (emit_q < lth_pkg::CNT_W'(lth_pkg::MAX_TOKENS)) begin
          if (slash_q) begin
            slash_d = 1'b0;
            if (c == "/") begin
              mode_d = lth_pkg::MODE_CMT;
            end else begin
              a_vld    = 1'b1;
              a_rec    = tok_rec(lth_pkg::TOK_OP, tb_q, tb_q + 7'd1, line_q);
              start_en = 1'b1;
            end
          end else begin
            case (mode_q)
              lth_pkg::MODE_STR: begin
                if (c == "\"") begin
                  a_vld  = 1'b1;
                  a_rec  = tok_rec(lth_pkg::TOK_STR, tb_q, col_q + 7'd1, line_q);
                  mode_d = lth_pkg::MODE_IDLE;
                end else if (c == "\\") begin
                  mode_d = lth_pkg::MODE_STR_ESC;
                end
              end
              lth_pkg::MODE_STR_ESC: begin
                mode_d = lth_pkg::MODE_STR;
              end
              lth_pkg::MODE_NUM: begin
                if (!(lth_pkg::is_digit(c) || c == "x")) begin
                  a_vld    = 1'b1;
                  a_rec    = tok_rec(lth_pkg::TOK_NUM, tb_q, col_q, line_q);
                  mode_d   = lth_pkg::MODE_IDLE;
                  start_en = 1'b1;
                end
              end
              lth_pkg::MODE_WORD: begin
                if ((lth_pkg::is_alpha(c) || lth_pkg::is_digit(c)) &&
                    len_q < lth_pkg::LEN_W'(lth_pkg::WORD_CAP)) begin
                  if (len_q < lth_pkg::LEN_W'(lth_pkg::HEAD_CHARS)) begin
                    head_d = {head_q[lth_pkg::HEAD_W-9:0], c};
                  end
                  len_d = len_q + 5'd1;
                end else begin
                  kind = lth_pkg::word_kind(head_q, len_q);
                  if (kind == lth_pkg::TOK_ABSENT && c == "(") kind = lth_pkg::TOK_FN;
                  a_vld    = (kind != lth_pkg::TOK_ABSENT);
                  a_rec    = tok_rec(kind, tb_q, col_q, line_q);
                  mode_d   = lth_pkg::MODE_IDLE;
                  start_en = 1'b1;
                end
              end
              lth_pkg::MODE_CMT, lth_pkg::MODE_PP: begin
              end
              default: begin
                start_en = 1'b1;
              end
            endcase
          end
        end
        col_d = col_q + 7'd1;
      end

      // A new token may start only while the per-line token budget has room.
      if (start_en &&
          (emit_q + lth_pkg::CNT_W'(a_vld)) < lth_pkg::CNT_W'(lth_pkg::MAX_TOKENS)) begin
        tb_d = col_q;
        if (c == " " || c == "\t") begin
        end else if (c == "/") begin
          slash_d = 1'b1;
        end else if (c == "\"") begin
          mode_d = lth_pkg::MODE_STR;
        end else if (lth_pkg::is_digit(c)) begin
          mode_d = lth_pkg::MODE_NUM;
        end else if (lth_pkg::is_alpha(c)) begin
          mode_d = lth_pkg::MODE_WORD;
          head_d = lth_pkg::HEAD_W'(c);
          len_d  = 5'd1;
        end else if (c == "#") begin
          mode_d = lth_pkg::MODE_PP;
        end else if (c == "+" || c == "-" || c == "*" || c == "=" || c == "<" ||
                     c == ">") begin
          s_vld = 1'b1;
          s_rec = tok_rec(lth_pkg::TOK_OP, col_q, col_q + 7'd1, line_q);
        end
      end
    end else begin
      if (emit_q < lth_pkg::CNT_W'(lth_pkg::MAX_TOKENS)) begin
        if (slash_q) begin
          a_vld = 1'b1;
          a_rec = tok_rec(lth_pkg::TOK_OP, tb_q, tb_q + 7'd1, line_q);
        end else begin
          case (mode_q)
            lth_pkg::MODE_STR, lth_pkg::MODE_STR_ESC: begin
              a_vld = 1'b1;
              a_rec = tok_rec(lth_pkg::TOK_STR, tb_q, col_q, line_q);
            end
            lth_pkg::MODE_NUM: begin
              a_vld = 1'b1;
              a_rec = tok_rec(lth_pkg::TOK_NUM, tb_q, col_q, line_q);
            end
            lth_pkg::MODE_WORD: begin
              kind  = lth_pkg::word_kind(head_q, len_q);
              a_vld = (kind != lth_pkg::TOK_ABSENT);
              a_rec = tok_rec(kind, tb_q, col_q, line_q);
            end
            lth_pkg::MODE_CMT: begin
              a_vld = 1'b1;
              a_rec = tok_rec(lth_pkg::TOK_CMT, tb_q, col_q, line_q);
            end
            lth_pkg::MODE_PP: begin
              a_vld = 1'b1;
              a_rec = tok_rec(lth_pkg::TOK_PP, tb_q, col_q, line_q);
            end
            default: begin
            end
          endcase
        end
      end
      s_vld             = 1'b1;
      s_rec             = tok_rec(lth_pkg::TOK_SUMMARY, '0, col_q, line_q);
      s_rec.token_count = emit_q + lth_pkg::CNT_W'(a_vld);
      s_rec.line_done   = 1'b1;
      mode_d  = lth_pkg::MODE_IDLE;
      slash_d = 1'b0;
      head_d  = '0;
      len_d   = '0;
      tb_d    = '0;
      col_d   = '0;
      line_d  = (line_q == lth_pkg::LINE_W'(lth_pkg::LINE_COUNT - 1)) ? '0 : line_q + 7'd1;
    end
  end

  always_comb begin
    if (in_data_i.req_type == lth_pkg::REQ_EOL) begin
      emit_d = '0;
    end else begin
      emit_d = emit_q + lth_pkg::CNT_W'(a_vld) + lth_pkg::CNT_W'(s_vld);
    end
  end

  assign push_o.n    = accept_i ? (2'(a_vld) + 2'(s_vld)) : 2'd0;
  assign push_o.rec0 = a_vld ? a_rec : s_rec;
  assign push_o.rec1 = s_rec;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= lth_pkg::MODE_IDLE;
      slash_q <= 1'b0;
      head_q  <= '0;
      len_q   <= '0;
      tb_q    <= '0;
      col_q   <= '0;
      emit_q  <= '0;
      line_q  <= '0;
    end else if (accept_i) begin
      mode_q  <= mode_d;
      slash_q <= slash_d;
      head_q  <= head_d;
      len_q   <= len_d;
      tb_q    <= tb_d;
      col_q   <= col_d;
      emit_q  <= emit_d;
      line_q  <= line_d;
    end
  end

  `LTH_ASSERT(a_col_bound, col_q <= lth_pkg::LINE_LEN, "column ran past the line length")
  `LTH_ASSERT(a_emit_bound, emit_q <= lth_pkg::MAX_TOKENS, "token budget exceeded")
  `LTH_ASSERT_IMP(a_slash_idle, slash_q, mode_q == lth_pkg::MODE_IDLE, "slash held inside a token")
  `LTH_ASSERT_IMP(a_word_len, mode_q == lth_pkg::MODE_WORD, len_q != '0 && len_q <= lth_pkg::WORD_CAP, "identifier length out of range")

endmodule

FILE: src/lth_outq.sv
// Result queue: takes up to two records per cycle and hands out one per transaction.
`include "line_token_highlighter_core_defines.svh"

module lth_outq (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  lth_pkg::lth_push_t push_i,
  output logic               ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output lth_pkg::lth_out_t  out_data_o
);

  lth_pkg::lth_out_t          mem_q [lth_pkg::QDEPTH];
  logic [lth_pkg::QPTR_W-1:0] wr_q, rd_q;
  logic [lth_pkg::QCNT_W-1:0] cnt_q;
  logic                       pop;

  assign out_valid_o = (cnt_q != '0);
  assign out_data_o  = mem_q[rd_q];
  assign pop         = out_valid_o && out_ready_i;
  // Room for the two records one transaction can produce.
  assign ready_o     = (cnt_q <= lth_pkg::QCNT_W'(lth_pkg::QDEPTH - 2));

  always_ff @(posedge clk_i) begin
    if (push_i.n != 2'd0) mem_q[wr_q] <= push_i.rec0;
    if (push_i.n == 2'd2) mem_q[wr_q + 2'd1] <= push_i.rec1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_q + lth_pkg::QPTR_W'(push_i.n);
      rd_q  <= rd_q + lth_pkg::QPTR_W'(pop);
      cnt_q <= cnt_q + lth_pkg::QCNT_W'(push_i.n) - lth_pkg::QCNT_W'(pop);
    end
  end

  `LTH_ASSERT(a_cnt_bound, cnt_q <= lth_pkg::QDEPTH, "result queue overflow")
  `LTH_ASSERT(a_ptr_cnt, cnt_q[lth_pkg::QPTR_W-1:0] == lth_pkg::QPTR_W'(wr_q - rd_q), "queue pointers disagree with fill count")
  `LTH_ASSERT_IMP(a_full_valid, !ready_o, out_valid_o, "queue stalls input while empty")

endmodule

FILE: src/line_token_highlighter_core.sv
// Top level of the line token highlighter: scanner followed by the result queue.
//
// Usage: feed one source line as a series of character transactions on the
// input channel (req_type 0, ch the byte), then one end-of-line transaction
// (req_type 1). Results leave on the output channel: highlight tokens (type,
// start column, end column) and, for every end of line, a summary record with
// line_done set, the line length in tok_end and the token count.
// The records of a transaction are registered in the result queue and reach the
// output in the cycle after it is accepted, when the queue is empty.
// Throughput: one input transaction per cycle while each produces at most one
// record and the receiver keeps up; two records of one transaction leave in turn.
// The four-entry result queue accepts input while it has room for two records,
// so a stalled receiver backs up into in_ready_o once three or four records wait.
// Reset clears the line state, the line counter and the result queue; the
// first line after reset is line 0.
module line_token_highlighter_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  lth_pkg::lth_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output lth_pkg::lth_out_t out_data_o
);

  logic               accept;
  lth_pkg::lth_push_t push;

  assign accept = in_valid_i && in_ready_o;

  lth_scan u_scan (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .in_data_i (in_data_i),
    .push_o    (push)
  );

  lth_outq u_outq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .ready_o     (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
